@@ hw/rtl/key_state_tracker_with_release_latch_macros.svh @@
// ----------------------------------------------------------------------------
// Key state tracker assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef KEY_STATE_TRACKER_WITH_RELEASE_LATCH_MACROS_SVH
`define KEY_STATE_TRACKER_WITH_RELEASE_LATCH_MACROS_SVH
`ifndef SYNTHESIS
`define KST_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("key state tracker assertion failed");
`define KST_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("key state tracker forbidden condition");
`else
`define KST_ASSERT(lbl, clk, rst_n, prop)
`define KST_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ hw/rtl/kst_pkg.sv @@
// ----------------------------------------------------------------------------
// Key state tracker package
// Types, register indexes and constants shared by the tracker RTL.
// ----------------------------------------------------------------------------
package kst_pkg;

	localparam int LatchDepthDefault = 10;
	localparam int NumKeys           = 256;
	localparam int NumCfg            = 5;
	localparam int NumRd             = NumCfg + 1;

	localparam logic [2:0] CfgLeftAlt   = 3'd0;
	localparam logic [2:0] CfgRightAlt  = 3'd1;
	localparam logic [2:0] CfgLeftCtrl  = 3'd2;
	localparam logic [2:0] CfgLeftShift = 3'd3;
	localparam logic [2:0] CfgRightShft = 3'd4;

	localparam logic [7:0] CfgReset [NumCfg] = '{8'd56, 8'd184, 8'd29, 8'd42, 8'd54};

	// read slot order: query key first, then the modifier registers
	localparam logic [2:0] RdQuery = 3'd0;

	typedef enum logic [1:0] {
		ACT_KEY   = 2'd0,
		ACT_TICK  = 2'd1,
		ACT_QUERY = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVT_RD,
		ST_EVT_WR,
		ST_DRAIN,
		ST_RD,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] scan_code;
		logic       extended;
		logic       key_up;
		logic [7:0] query_key;
	} kst_req_t;

	typedef struct packed {
		logic       key_down;
		logic       alt_down;
		logic       control_down;
		logic       shift_down;
		logic [7:0] last_pressed;
		logic [3:0] latched_count;
		logic [7:0] frame_number;
	} kst_rsp_t;

endpackage

@@ hw/rtl/kst_ram.sv @@
// ----------------------------------------------------------------------------
// Key state tracker RAM
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module kst_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/key_state_tracker_with_release_latch.sv @@
// ----------------------------------------------------------------------------
// Key state tracker with release latch
// Per-key down map with same-frame release latch, frame counter and
// modifier flags; one RAM port pair walked by a small sequencer.
// ----------------------------------------------------------------------------
// channel   handshake         payload
// input     start, busy       req  (kst_req_t)
// result    done (strobe)     rsp  (kst_rsp_t)
// config    cfg_we            cfg_index, cfg_data
//
// Actions end in ST_RD, ST_FIN, ST_OUT; key events run ST_EVT_RD, ST_EVT_WR,
// frame ticks ST_DRAIN, one latched key cleared per cycle on the down RAM
// write port. The six down-state reads (query key, five modifiers) share the
// one RAM read port. Reset is immediate: per-key valid flops read as released
// and frame zero. Results cannot be stalled; done is high for one cycle.
// ----------------------------------------------------------------------------
`include "key_state_tracker_with_release_latch_macros.svh"

module key_state_tracker_with_release_latch
	import kst_pkg::*;
#(
	parameter int LatchDepth = LatchDepthDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  kst_req_t   req,
	output logic       done,
	output kst_rsp_t   rsp,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	localparam int CntW = $clog2(LatchDepth + 1);
	localparam int IdxW = (LatchDepth > 1) ? $clog2(LatchDepth) : 1;

	state_t state_q, state_d;

	logic [7:0]      cfg_q [NumCfg];
	logic [NumKeys-1:0] valid_q;
	logic [7:0]      latch_q [LatchDepth];
	logic [CntW-1:0] cnt_q;
	logic [CntW-1:0] cnt_dec;
	logic [IdxW-1:0] pop_idx;
	logic [7:0]      frame_q;
	logic [7:0]      last_q;
	logic [7:0]      code_q;
	logic            key_up_q;
	logic [7:0]      query_q;
	logic [2:0]      rd_idx_q;
	logic [NumRd-1:0] hits_q;
	logic            done_q;
	kst_rsp_t        rsp_q;

	logic            rd_vld_s1;
	logic [2:0]      rd_idx_s1;
	logic            ent_vld_s1;

	logic            accept;
	logic            down_we;
	logic [7:0]      down_waddr;
	logic            down_wdata;
	logic            down_rdata;
	logic            frame_we;
	logic [7:0]      frame_rdata;
	logic [7:0]      rd_addr;
	logic [7:0]      vld_addr;
	logic [7:0]      pf;
	logic            latch_push;
	logic            drain_pop;
	logic            rd_issue;
	logic            out_load;

	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);
	assign done    = done_q;
	assign rsp     = rsp_q;
	assign cnt_dec = cnt_q - CntW'(1);
	assign pop_idx = cnt_dec[IdxW-1:0];
	assign pf      = ent_vld_s1 ? frame_rdata : 8'd0;

	always_comb begin
		case (rd_idx_q)
			RdQuery: rd_addr = query_q;
			3'd1:    rd_addr = cfg_q[CfgLeftAlt];
			3'd2:    rd_addr = cfg_q[CfgRightAlt];
			3'd3:    rd_addr = cfg_q[CfgLeftCtrl];
			3'd4:    rd_addr = cfg_q[CfgLeftShift];
			3'd5:    rd_addr = cfg_q[CfgRightShft];
			default: rd_addr = query_q;
		endcase
	end

	assign vld_addr = (state_q == ST_EVT_RD) ? code_q : rd_addr;

	kst_ram #(.Width(1), .Depth(NumKeys)) u_down_ram (
		.clk   (clk),
		.we    (down_we),
		.waddr (down_waddr),
		.wdata (down_wdata),
		.raddr (rd_addr),
		.rdata (down_rdata)
	);

	kst_ram #(.Width(8), .Depth(NumKeys)) u_frame_ram (
		.clk   (clk),
		.we    (frame_we),
		.waddr (code_q),
		.wdata (frame_q),
		.raddr (code_q),
		.rdata (frame_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		down_we    = 1'b0;
		down_waddr = code_q;
		down_wdata = 1'b0;
		frame_we   = 1'b0;
		latch_push = 1'b0;
		drain_pop  = 1'b0;
		rd_issue   = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.action)
						ACT_KEY:  state_d = ST_EVT_RD;
						ACT_TICK: state_d = ST_DRAIN;
						default:  state_d = ST_RD;
					endcase
				end
			end
			ST_EVT_RD: begin
				state_d = ST_EVT_WR;
			end
			ST_EVT_WR: begin
				if (key_up_q) begin
					if (pf == frame_q && cnt_q < CntW'(LatchDepth)) begin
						latch_push = 1'b1;
					end else begin
						down_we = valid_q[code_q];
					end
				end else begin
					down_we    = 1'b1;
					down_wdata = 1'b1;
					frame_we   = 1'b1;
				end
				state_d = ST_RD;
			end
			ST_DRAIN: begin
				if (cnt_q != '0) begin
					drain_pop  = 1'b1;
					down_waddr = latch_q[pop_idx];
					down_we    = valid_q[latch_q[pop_idx]];
				end else begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				rd_issue = 1'b1;
				if (rd_idx_q == 3'(NumRd - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_load = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumCfg; i++) begin
				cfg_q[i] <= CfgReset[i];
			end
			valid_q   <= '0;
			cnt_q     <= '0;
			frame_q   <= '0;
			last_q    <= '0;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			if (cfg_we && cfg_index < 3'(NumCfg)) begin
				cfg_q[cfg_index] <= cfg_data;
			end
			if (accept && req.action == ACT_TICK) begin
				frame_q <= frame_q + 8'd1;
			end
			if (frame_we) begin
				valid_q[code_q] <= 1'b1;
				last_q          <= code_q;
			end
			if (latch_push) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (drain_pop) begin
				cnt_q <= cnt_dec;
			end
			if (rd_issue) begin
				rd_idx_q <= (rd_idx_q == 3'(NumRd - 1)) ? 3'd0 : rd_idx_q + 3'd1;
			end
			rd_vld_s1 <= rd_issue;
			done_q    <= out_load;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			code_q   <= req.scan_code + {req.extended, 7'd0};
			key_up_q <= req.key_up;
			query_q  <= req.query_key;
		end
		if (latch_push) begin
			latch_q[cnt_q[IdxW-1:0]] <= code_q;
		end
		ent_vld_s1 <= valid_q[vld_addr];
		rd_idx_s1  <= rd_idx_q;
		if (rd_vld_s1) begin
			hits_q[rd_idx_s1] <= ent_vld_s1 & down_rdata;
		end
		if (out_load) begin
			rsp_q.key_down      <= hits_q[RdQuery];
			rsp_q.alt_down      <= hits_q[CfgLeftAlt + 3'd1] | hits_q[CfgRightAlt + 3'd1];
			rsp_q.control_down  <= hits_q[CfgLeftCtrl + 3'd1];
			rsp_q.shift_down    <= hits_q[CfgLeftShift + 3'd1] | hits_q[CfgRightShft + 3'd1];
			rsp_q.last_pressed  <= last_q;
			rsp_q.latched_count <= 4'(cnt_q);
			rsp_q.frame_number  <= frame_q;
		end
	end

	`KST_ASSERT(a_done_after_out, clk, arst_n, done_q |-> $past(state_q == ST_OUT))
	`KST_ASSERT(a_done_idle, clk, arst_n, done_q |-> !busy)
	`KST_ASSERT(a_accept_busy, clk, arst_n, (start && !busy) |=> busy)
	`KST_NEVER(a_cnt_range, clk, arst_n, cnt_q > CntW'(LatchDepth))
	`KST_NEVER(a_push_pop, clk, arst_n, latch_push && state_q != ST_EVT_WR)

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Key state tracker testbench
// Drives command transactions through a queue-fed driver and checks every
// report against a local model of the down map, the press stamps, the
// same-frame release list, the frame counter and the modifier flags. Three
// phases change the modifier codes and the sender idle rate. Each phase has
// bursts of presses and releases within one frame and random noise; the
// second adds a run of ticks that wraps the frame stamp.
// ----------------------------------------------------------------------------
module tb
	import kst_pkg::*;
();

	localparam logic [1:0] ActSpare   = 2'd3;	// spare action code, reads like a query
	localparam int         QuietLimit = 4000;
	localparam int         HeldIdxW   = $clog2(LatchDepthDefault);

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     start     = 1'b0;
	logic     busy;
	kst_req_t req       = '0;
	logic     done;
	kst_rsp_t rsp;
	logic       cfg_we    = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [7:0] cfg_data  = '0;

	key_state_tracker_with_release_latch dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// key state model
	bit          key_map   [NumKeys];
	bit [7:0]    stamp     [NumKeys];
	bit [7:0]    held_keys [LatchDepthDefault];
	int unsigned held_count;
	bit [7:0]    frame_ctr;
	bit [7:0]    last_code;
	logic [7:0]  mod_code  [NumCfg];

	kst_req_t queued_events [$];
	kst_rsp_t due_reports   [$];

	int unsigned sender_idle_pct = 0;
	int          n_errors   = 0;
	int          n_accepted = 0;
	int          n_checked  = 0;
	int          n_ticks    = 0;
	int          n_held     = 0;
	int          n_overflow = 0;
	int          quiet_cycles = 0;

	function automatic kst_rsp_t track_key_item(kst_req_t r);
		kst_rsp_t   o;
		logic [7:0] code;
		code = r.scan_code + {r.extended, 7'b0};
		if (r.action == ACT_KEY) begin
			if (r.key_up) begin
				if (stamp[code] == frame_ctr && held_count < LatchDepthDefault) begin
					held_keys[HeldIdxW'(held_count)] = code;
					held_count++;
					n_held++;
				end else begin
					key_map[code] = 1'b0;
					if (stamp[code] == frame_ctr)
						n_overflow++;
				end
			end else begin
				stamp[code]   = frame_ctr;
				key_map[code] = 1'b1;
				last_code     = code;
			end
		end else if (r.action == ACT_TICK) begin
			frame_ctr++;
			n_ticks++;
			while (held_count > 0) begin
				held_count--;
				key_map[held_keys[HeldIdxW'(held_count)]] = 1'b0;
			end
		end
		o.key_down      = key_map[r.query_key];
		o.alt_down      = key_map[mod_code[CfgLeftAlt]] | key_map[mod_code[CfgRightAlt]];
		o.control_down  = key_map[mod_code[CfgLeftCtrl]];
		o.shift_down    = key_map[mod_code[CfgLeftShift]] | key_map[mod_code[CfgRightShft]];
		o.last_pressed  = last_code;
		o.latched_count = 4'(held_count);
		o.frame_number  = frame_ctr;
		return o;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req   <= '0;
		end else begin
			if (start && !busy) begin
				due_reports.push_back(track_key_item(req));
				n_accepted++;
			end
			if (!start || !busy) begin
				if (queued_events.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					req   <= queued_events.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			n_errors++;
		end
	endfunction

	// monitor
	always @(posedge clk) begin
		kst_rsp_t want;
		if (done === 1'b1) begin
			if (due_reports.size() == 0) begin
				$error("report with no transaction outstanding");
				n_errors++;
			end else begin
				want = due_reports.pop_front();
				check_field("key_down", 8'(want.key_down), 8'(rsp.key_down));
				check_field("alt_down", 8'(want.alt_down), 8'(rsp.alt_down));
				check_field("control_down", 8'(want.control_down), 8'(rsp.control_down));
				check_field("shift_down", 8'(want.shift_down), 8'(rsp.shift_down));
				check_field("last_pressed", want.last_pressed, rsp.last_pressed);
				check_field("latched_count", 8'(want.latched_count),
					8'(rsp.latched_count));
				check_field("frame_number", want.frame_number, rsp.frame_number);
				n_checked++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done === 1'b1)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QuietLimit)
			@(posedge clk);
		$display("tb: done, errors");
		$finish;
	end

	function automatic void add_item(logic [1:0] act, logic [7:0] scan, logic ext, logic up,
			logic [7:0] qkey);
		kst_req_t r;
		r.action    = act;
		r.scan_code = scan;
		r.extended  = ext;
		r.key_up    = up;
		r.query_key = qkey;
		queued_events.push_back(r);
	endfunction

	// same code reached with or without the extended bit
	function automatic void add_key(logic [7:0] code, logic up, logic [7:0] qkey);
		logic ext;
		ext = 1'($urandom_range(1));
		add_item(ACT_KEY, code - {ext, 7'b0}, ext, up, qkey);
	endfunction

	function automatic logic [7:0] pick_code();
		if ($urandom_range(99) < 35)
			return mod_code[3'($urandom_range(NumCfg - 1))];
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] pick_query(logic [7:0] near);
		int unsigned r;
		r = $urandom_range(9);
		if (r < 4)
			return near;
		if (r < 7)
			return mod_code[3'($urandom_range(NumCfg - 1))];
		return 8'($urandom);
	endfunction

	// presses then releases within one frame, usually closed by a tick
	function automatic int queue_burst();
		logic [7:0] keys [$];
		logic [7:0] tmp;
		int         n;
		int         j;
		int         count;
		n     = $urandom_range(1, 14);
		count = 0;
		for (int i = 0; i < n; i++) begin
			keys.push_back(pick_code());
			add_key(keys[i], 1'b0, pick_query(keys[i]));
			count++;
			if ($urandom_range(3) == 0) begin
				add_item(ACT_QUERY, 8'($urandom), 1'($urandom), 1'($urandom),
					pick_query(keys[i]));
				count++;
			end
		end
		for (int i = 0; i < n; i++) begin
			j       = $urandom_range(i, n - 1);
			tmp     = keys[i];
			keys[i] = keys[j];
			keys[j] = tmp;
		end
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 85) begin
				add_key(keys[i], 1'b1, pick_query(keys[i]));
				count++;
				if ($urandom_range(5) == 0) begin
					add_key(keys[i], 1'b1, pick_query(keys[i]));
					count++;
				end
				if ($urandom_range(9) == 0) begin
					add_key(keys[i], 1'b0, pick_query(keys[i]));
					count++;
				end
			end
		end
		if ($urandom_range(4) != 0) begin
			add_item(ACT_TICK, 8'($urandom), 1'($urandom), 1'($urandom),
				pick_query(keys[0]));
			count++;
		end
		return count;
	endfunction

	function automatic int queue_noise();
		int          n;
		int unsigned r;
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 20)
				add_key(pick_code(), 1'($urandom), pick_query(8'($urandom)));
			else if (r < 40)
				add_item(ACT_KEY, 8'($urandom), 1'($urandom), 1'($urandom),
					pick_query(8'($urandom)));
			else if (r < 55)
				add_item(ACT_TICK, 8'($urandom), 1'($urandom), 1'($urandom),
					pick_query(8'($urandom)));
			else if (r < 95)
				add_item(ACT_QUERY, 8'($urandom), 1'($urandom), 1'($urandom),
					pick_query(8'($urandom)));
			else
				add_item(ActSpare, 8'($urandom), 1'($urandom), 1'($urandom),
					pick_query(8'($urandom)));
		end
		return n;
	endfunction

	task automatic settle();
		while (queued_events.size() != 0 || start || busy || due_reports.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (int'(idx) < NumCfg)
			mod_code[idx] = val;
	endtask

	task automatic program_modifiers(input logic [7:0] l_alt, input logic [7:0] r_alt,
			input logic [7:0] l_ctrl, input logic [7:0] l_shift, input logic [7:0] r_shift);
		write_reg(CfgLeftAlt, l_alt);
		write_reg(CfgRightAlt, r_alt);
		write_reg(CfgLeftCtrl, l_ctrl);
		write_reg(CfgLeftShift, l_shift);
		write_reg(CfgRightShft, r_shift);
	endtask

	task automatic run_random_phase(input int item_goal);
		int placed;
		int pause_at;
		placed   = 0;
		pause_at = 150;
		while (placed < item_goal) begin
			if ($urandom_range(99) < 60)
				placed += queue_burst();
			else
				placed += queue_noise();
			if (placed >= pause_at) begin
				settle();
				pause_at += 150 + $urandom_range(100);
			end
		end
		settle();
	endtask

	initial begin
		logic [7:0] k;
		logic [7:0] a;
		for (int i = 0; i < NumCfg; i++)
			mod_code[3'(i)] = CfgReset[3'(i)];
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		sender_idle_pct = 27;
		add_item(ACT_QUERY, 8'h00, 1'b0, 1'b0, 8'h00);
		add_item(ACT_KEY,   8'h00, 1'b0, 1'b1, 8'h00);	// release of unpressed key in frame 0
		add_item(ACT_KEY,   8'h2A, 1'b0, 1'b0, 8'h2A);
		add_item(ACT_KEY,   8'h38, 1'b1, 1'b0, 8'hB8);
		add_item(ACT_KEY,   8'h1D, 1'b0, 1'b0, 8'h1D);
		add_item(ACT_KEY,   8'hFF, 1'b1, 1'b0, 8'h7F);	// code wraps
		add_item(ACT_KEY,   8'hFF, 1'b0, 1'b0, 8'hFF);
		add_item(ACT_KEY,   8'h2A, 1'b0, 1'b1, 8'h2A);	// same-frame release held
		add_item(ACT_KEY,   8'h2A, 1'b0, 1'b1, 8'h2A);	// held twice
		add_item(ACT_KEY,   8'h2A, 1'b0, 1'b0, 8'h2A);	// press of held key
		add_item(ACT_TICK,  8'hFF, 1'b1, 1'b1, 8'h2A);
		add_item(ActSpare,  8'hFF, 1'b1, 1'b1, 8'hB8);
		add_item(ACT_KEY,   8'h1D, 1'b0, 1'b1, 8'h1D);	// pressed in older frame
		add_item(ACT_KEY,   8'h36, 1'b0, 1'b0, 8'h36);
		add_item(ACT_KEY,   8'h38, 1'b0, 1'b0, 8'h38);
		add_item(ACT_QUERY, 8'hFF, 1'b1, 1'b1, 8'h80);
		add_item(ACT_TICK,  8'h00, 1'b0, 1'b0, 8'h36);
		add_item(ACT_KEY,   8'h36, 1'b0, 1'b1, 8'h36);
		add_item(ACT_KEY,   8'h38, 1'b1, 1'b1, 8'hB8);
		add_item(ACT_QUERY, 8'h00, 1'b0, 1'b0, 8'hFF);
		settle();

		program_modifiers(8'h00, 8'hFF, 8'hFF, 8'h00, 8'h7F);
		for (int i = NumCfg; i < 8; i++)
			write_reg(3'(i), 8'($urandom));
		run_random_phase(540);

		sender_idle_pct = 56;
		a = 8'($urandom);
		program_modifiers(a, a, 8'($urandom), 8'($urandom), 8'($urandom));
		// stamp wraps after 256 frames and counts as this frame again
		k = 8'($urandom);
		add_item(ACT_TICK, 8'($urandom), 1'($urandom), 1'($urandom), k);
		add_key(k, 1'b0, k);
		repeat (256)
			add_item(ACT_TICK, 8'($urandom), 1'($urandom), 1'($urandom), k);
		add_key(k, 1'b1, k);
		add_item(ACT_QUERY, 8'($urandom), 1'($urandom), 1'($urandom), k);
		settle();
		run_random_phase(540);

		sender_idle_pct = 0;
		program_modifiers(8'hFF, 8'h00, 8'h00, 8'hFF, 8'h80);
		run_random_phase(540);

		repeat (30) @(posedge clk);
		$display("tb: %0d transactions, %0d reports checked, %0d frame ticks",
			n_accepted, n_checked, n_ticks);
		$display("tb: %0d releases held to frame end, %0d turned away by a full list",
			n_held, n_overflow);
		if (n_errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
